/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared property wrappers, clocked on i_clk; all but ASSERT_NEXT_RST are quiet while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/hhe_pkg.sv */
// ----------------------------------------------------------------------------
// hhe_pkg
// types, constants and header pattern for the host header extractor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hhe_pkg;

    localparam int MAX_HOST_DEF = 256;
    localparam int PAT_LEN      = 8;
    localparam int MP_W         = $clog2(PAT_LEN);

    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;

    // CR LF "Host: "
    localparam logic [7:0] HDR_PAT [PAT_LEN] = '{
        8'd13, 8'd10, 8'h48, 8'h6f, 8'h73, 8'h74, 8'h3a, 8'h20
    };

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_HOST   = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BYTES = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_LONG  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [1:0]  byte_count;
        logic [7:0]  host_length;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

endpackage

/* hw/rtl/hhe_step.sv */
// ----------------------------------------------------------------------------
// hhe_step
// per-byte header matcher and host byte tracker, one item per cycle while i_accept is high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hhe_step
    import hhe_pkg::*;
#(
    parameter int MAX_HOST = MAX_HOST_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_packet,
    output t_push      o_push
);

    localparam int CNT_W = $clog2(MAX_HOST);

    t_phase             r_phase,      n_phase;
    logic [MP_W-1:0]    r_match_pos,  n_match_pos;
    logic               r_held_cr,    n_held_cr;
    logic [CNT_W-1:0]   r_host_count, n_host_count;

    logic [1:0]         add;
    logic [7:0]         e0;
    logic [7:0]         e1;
    logic               done;
    logic [CNT_W:0]     sum;
    t_push              push;

    always_comb begin
        n_phase      = r_phase;
        n_match_pos  = r_match_pos;
        n_held_cr    = r_held_cr;
        n_host_count = r_host_count;
        add          = 2'd0;
        e0           = 8'd0;
        e1           = 8'd0;
        done         = 1'b0;
        sum          = {1'b0, r_host_count};
        push         = '0;

        case (r_phase)
            PH_SEARCH: begin
                if (i_data_byte == HDR_PAT[r_match_pos]) begin
                    if (r_match_pos == MP_W'(PAT_LEN - 1)) begin
                        n_phase      = PH_HOST;
                        n_match_pos  = '0;
                        n_held_cr    = 1'b0;
                        n_host_count = '0;
                    end else begin
                        n_match_pos = r_match_pos + MP_W'(1);
                    end
                end else begin
                    // only the pattern head is a CR, so a CR restarts at one
                    n_match_pos = (i_data_byte == CH_CR) ? MP_W'(1) : '0;
                end
            end
            PH_HOST: begin
                if (r_held_cr) begin
                    if (i_data_byte == CH_LF) begin
                        done = 1'b1;
                    end else if (i_data_byte == CH_CR) begin
                        add = 2'd1;
                        e0  = CH_CR;
                    end else begin
                        add       = 2'd2;
                        e0        = CH_CR;
                        e1        = i_data_byte;
                        n_held_cr = 1'b0;
                    end
                end else if (i_data_byte == CH_CR) begin
                    n_held_cr = 1'b1;
                end else begin
                    add = 2'd1;
                    e0  = i_data_byte;
                end

                sum = {1'b0, r_host_count} + (CNT_W + 1)'(add);

                if (done) begin
                    push.valid           = 1'b1;
                    push.res.kind        = KIND_DONE;
                    push.res.host_length = 8'(r_host_count);
                    n_phase              = PH_DONE;
                    n_held_cr            = 1'b0;
                end else if (add != 2'd0) begin
                    if (sum >= (CNT_W + 1)'(MAX_HOST)) begin
                        push.valid    = 1'b1;
                        push.res.kind = KIND_LONG;
                        n_phase       = PH_DONE;
                        n_held_cr     = 1'b0;
                    end else begin
                        n_host_count         = sum[CNT_W-1:0];
                        push.valid           = 1'b1;
                        push.res.kind        = KIND_BYTES;
                        push.res.first_byte  = e0;
                        push.res.second_byte = e1;
                        push.res.byte_count  = add;
                    end
                end
            end
            default: begin
                // finished for this packet: bytes ignored
            end
        endcase

        if (i_end_of_packet) begin
            if (n_phase inside {PH_SEARCH, PH_HOST}) begin
                push.valid = 1'b1;
                push.res   = '0;
                push.res.kind = KIND_NONE;
            end
            n_phase      = PH_SEARCH;
            n_match_pos  = '0;
            n_held_cr    = 1'b0;
            n_host_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SEARCH;
            r_match_pos  <= '0;
            r_held_cr    <= 1'b0;
            r_host_count <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_match_pos  <= n_match_pos;
            r_held_cr    <= n_held_cr;
            r_host_count <= n_host_count;
        end
    end

    assign o_push.valid = push.valid & i_accept;
    assign o_push.res   = push.res;

endmodule

/* hw/rtl/hhe_out_buf.sv */
// ----------------------------------------------------------------------------
// hhe_out_buf
// result register with a skid stage, registered stall toward the input side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hhe_out_buf
    import hhe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_stall,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    take;

    assign take = !r_main_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push.valid;
            end
        end else if (i_push.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_main <= r_skid_valid ? r_skid : i_push.res;
        end
        if (!take && i_push.valid) begin
            r_skid <= i_push.res;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_res   = r_main;

endmodule

/* hw/rtl/http_host_header_extractor_core.sv */
// ----------------------------------------------------------------------------
// http_host_header_extractor_core
// finds the first CR LF "Host: " in a packet and streams out the host name
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

// channel   direction  handshake            payload
// input     in         i_valid / o_stall    i_data_byte, i_end_of_packet
// result    out        o_valid / i_stall    o_kind, o_first_byte, o_second_byte,
//                                           o_byte_count, o_host_length
//
// one item per cycle unless stalled; the matcher state updates in the cycle an
// item is taken and its result (at most one) lands in a result register on the
// same edge; a skid register catches one result while o_valid is stalled;
// o_stall is its full flag: the input stalls only after the result side stalls
// reset (i_rst_n low, synchronous) clears the matcher and both result registers

module http_host_header_extractor_core
    import hhe_pkg::*;
#(
    parameter int MAX_HOST = MAX_HOST_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_packet,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_first_byte,
    output logic [7:0] o_second_byte,
    output logic [1:0] o_byte_count,
    output logic [7:0] o_host_length
);

    logic    accept;
    logic    buf_full;
    t_push   push;
    t_result res;

    // input item taken whenever the skid register is empty
    assign accept  = i_valid && !buf_full;
    assign o_stall = buf_full;

    // pattern matcher and host byte tracker
    hhe_step #(
        .MAX_HOST (MAX_HOST)
    ) u_step (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_end_of_packet (i_end_of_packet),
        .o_push          (push)
    );

    // result register plus skid
    hhe_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_stall (i_stall),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .o_res   (res)
    );

    assign o_kind        = res.kind;
    assign o_first_byte  = res.first_byte;
    assign o_second_byte = res.second_byte;
    assign o_byte_count  = res.byte_count;
    assign o_host_length = res.host_length;

    // a full skid register always sits behind a shown result
    `ASSERT_IMPL(a_skid_behind_main, o_stall, o_valid, "skid full without result")

    // host byte results always carry one or two bytes
    `ASSERT_IMPL(a_bytes_counted, o_valid && o_kind == KIND_BYTES,
        o_byte_count == 2'd1 || o_byte_count == 2'd2, "host byte result without bytes")

    // every result taken in leaves o_valid high the next cycle, never lost
    `ASSERT_NEXT(a_push_lands, push.valid && !o_stall, o_valid, "result not registered")

    // reset empties both result registers
    `ASSERT_NEXT_RST(a_reset_clears, !i_rst_n, !o_valid && !o_stall, "result left after reset")

endmodule

/* bench/http_host_header_extractor_core_test.sv */
// ----------------------------------------------------------------------------
// http_host_header_extractor_core_test
// drives packets through the host header extractor with random idle gaps and
// result stalls, predicts every result in a small tracker and checks each one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// mirrors the extractor state and keeps the results still owed by the block
class host_tracker;
    hhe_pkg::t_phase  phase;
    logic [3:0]       match_pos;
    logic             held_cr;
    logic [8:0]       host_count;
    hhe_pkg::t_result host_results_due[$];
    int               errors;

    function new();
        clear_state();
        errors = 0;
    endfunction

    function void clear_state();
        phase      = hhe_pkg::PH_SEARCH;
        match_pos  = '0;
        held_cr    = 1'b0;
        host_count = '0;
    endfunction

    // notes one accepted item; returns 1 when the block just ignores it
    function bit take_byte(logic [7:0] data_b, logic last);
        hhe_pkg::t_result res;
        bit               have;
        bit               done;
        bit               ignored;
        logic [3:0]       mp;
        logic [1:0]       add;
        logic [7:0]       e0;
        logic [7:0]       e1;
        res     = '0;
        have    = 1'b0;
        done    = 1'b0;
        add     = '0;
        e0      = '0;
        e1      = '0;
        ignored = (phase != hhe_pkg::PH_SEARCH) && (phase != hhe_pkg::PH_HOST) && !last;
        case (phase)
            hhe_pkg::PH_SEARCH: begin
                mp = {1'b0, match_pos[2:0]};
                if (data_b == hhe_pkg::HDR_PAT[mp[2:0]]) begin
                    mp = mp + 4'd1;
                end else begin
                    mp = (data_b == hhe_pkg::CH_CR) ? 4'd1 : 4'd0;
                end
                if (mp >= hhe_pkg::PAT_LEN) begin
                    phase      = hhe_pkg::PH_HOST;
                    match_pos  = '0;
                    held_cr    = 1'b0;
                    host_count = '0;
                end else begin
                    match_pos = mp;
                end
            end
            hhe_pkg::PH_HOST: begin
                if (held_cr) begin
                    if (data_b == hhe_pkg::CH_LF) begin
                        done = 1'b1;
                    end else if (data_b == hhe_pkg::CH_CR) begin
                        // release the old cr, hold the new one
                        add = 2'd1;
                        e0  = hhe_pkg::CH_CR;
                    end else begin
                        add     = 2'd2;
                        e0      = hhe_pkg::CH_CR;
                        e1      = data_b;
                        held_cr = 1'b0;
                    end
                end else if (data_b == hhe_pkg::CH_CR) begin
                    held_cr = 1'b1;
                end else begin
                    add = 2'd1;
                    e0  = data_b;
                end
                if (done) begin
                    have            = 1'b1;
                    res.kind        = hhe_pkg::KIND_DONE;
                    res.host_length = host_count[7:0];
                    phase           = hhe_pkg::PH_DONE;
                    held_cr         = 1'b0;
                end else if (add != 2'd0) begin
                    have = 1'b1;
                    if (int'(host_count) + int'(add) >= hhe_pkg::MAX_HOST_DEF) begin
                        res.kind = hhe_pkg::KIND_LONG;
                        phase    = hhe_pkg::PH_DONE;
                        held_cr  = 1'b0;
                    end else begin
                        host_count      = host_count + add;
                        res.kind        = hhe_pkg::KIND_BYTES;
                        res.first_byte  = e0;
                        res.second_byte = e1;
                        res.byte_count  = add;
                    end
                end
            end
            default: ;
        endcase
        if (last) begin
            // no outcome in this packet: report not found, drop any bytes
            if (phase != hhe_pkg::PH_DONE) begin
                have     = 1'b1;
                res      = '0;
                res.kind = hhe_pkg::KIND_NONE;
            end
            clear_state();
        end
        if (have) host_results_due.push_back(res);
        return ignored;
    endfunction

    function bit field_ok(string name, int exp_v, int got_v);
        if (exp_v != got_v) begin
            $display("%0t ns: %s expected %0d got %0d", $time, name, exp_v, got_v);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function void check_result(hhe_pkg::t_result got);
        hhe_pkg::t_result exp_r;
        bit               ok;
        if (host_results_due.size() == 0) begin
            $write("%0t ns: unexpected result, expected none got kind %0d first %0d ",
                   $time, got.kind, got.first_byte);
            $display("second %0d count %0d length %0d", got.second_byte, got.byte_count,
                     got.host_length);
            errors++;
            return;
        end
        exp_r = host_results_due.pop_front();
        ok = field_ok("kind", exp_r.kind, got.kind)
           & field_ok("first_byte", exp_r.first_byte, got.first_byte)
           & field_ok("second_byte", exp_r.second_byte, got.second_byte)
           & field_ok("byte_count", exp_r.byte_count, got.byte_count)
           & field_ok("host_length", exp_r.host_length, got.host_length);
        if (!ok) errors++;
    endfunction
endclass

module http_host_header_extractor_core_test;
    import hhe_pkg::*;

    localparam int RESET_CYCLES = 10;
    localparam int ITEM_TARGET  = 1300;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int HOLD_START   = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_valid         = 1'b0;
    logic [7:0] i_data_byte     = '0;
    logic       i_end_of_packet = 1'b0;
    logic       i_stall         = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_kind;
    logic [7:0] o_first_byte;
    logic [7:0] o_second_byte;
    logic [1:0] o_byte_count;
    logic [7:0] o_host_length;

    host_tracker tracker;
    int          cycles     = 0;
    int          items_used = 0;
    bit          burst      = 1'b0;
    bit          held_long  = 1'b0;
    logic [7:0]  pkt_data[$];

    http_host_header_extractor_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_packet (i_end_of_packet),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_first_byte    (o_first_byte),
        .o_second_byte   (o_second_byte),
        .o_byte_count    (o_byte_count),
        .o_host_length   (o_host_length)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: values seen here are the ones held before the edge
    always @(posedge i_clk) begin : take_result
        t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.kind        = t_kind'(o_kind);
            got.first_byte  = o_first_byte;
            got.second_byte = o_second_byte;
            got.byte_count  = o_byte_count;
            got.host_length = o_host_length;
            tracker.check_result(got);
        end
    end

    // receiver stalls, with one long hold-off so the skid fills and the input stalls
    initial begin : stall_gen
        int r;
        while (!i_rst_n) @(posedge i_clk);
        @(posedge i_clk);
        forever begin
            if (!held_long && cycles >= HOLD_START) begin
                held_long = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            r = $urandom_range(0, 99);
            i_stall <= 1'b0;
            repeat (r < 15 ? $urandom_range(60, 150) : $urandom_range(1, 12)) @(posedge i_clk);
            r = $urandom_range(0, 99);
            i_stall <= 1'b1;
            repeat (r < 85 ? $urandom_range(1, 3) : $urandom_range(8, 40)) @(posedge i_clk);
        end
    end

    task automatic send_item(input logic [7:0] data_b, input logic last);
        int r;
        int gap;
        r   = $urandom_range(0, 99);
        gap = 0;
        if (!burst) begin
            if (r >= 98)      gap = $urandom_range(20, 60);
            else if (r >= 90) gap = $urandom_range(4, 12);
            else if (r >= 65) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_data_byte     <= data_b;
        i_end_of_packet <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (!tracker.take_byte(data_b, last)) items_used++;
    endtask

    task automatic send_packet();
        burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < pkt_data.size(); i++) begin
            send_item(pkt_data[i], i == pkt_data.size() - 1);
        end
        pkt_data.delete();
    endtask

    // first n bytes of the header pattern
    task automatic add_header(input int n);
        for (int i = 0; i < n; i++) pkt_data.push_back(HDR_PAT[i]);
    endtask

    task automatic add_random(input int n);
        for (int i = 0; i < n; i++) pkt_data.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_text(input string txt);
        for (int i = 0; i < txt.len(); i++) pkt_data.push_back(txt[i]);
    endtask

    // host name bytes with plenty of carriage returns mixed in
    task automatic add_host(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0) pkt_data.push_back(CH_CR);
            else                           pkt_data.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        int pkt_no;
        int r;
        int len;
        tracker = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // header with extreme host bytes, cr cr, cr x, then cr lf and a byte
        // that the finished phase ignores
        pkt_data.push_back(8'hff);
        add_header(PAT_LEN);
        pkt_data.push_back(8'h00);
        pkt_data.push_back(8'hff);
        pkt_data.push_back(CH_CR);
        pkt_data.push_back(CH_CR);
        add_text("x");
        pkt_data.push_back(CH_CR);
        pkt_data.push_back(CH_LF);
        add_text("z");
        send_packet();
        // match ending on the last byte of the packet
        add_header(PAT_LEN);
        send_packet();
        // no header at all
        add_text("A");
        send_packet();

        pkt_no = 0;
        while (items_used < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                // request with a header, mostly closed by cr lf, now and then a host near the length limit
                add_random($urandom_range(0, 6));
                add_header(PAT_LEN);
                len = (pkt_no % 16 == 2) ? $urandom_range(252, 258) : $urandom_range(0, 12);
                add_host(len);
                if ($urandom_range(0, 99) < 85) begin
                    pkt_data.push_back(CH_CR);
                    pkt_data.push_back(CH_LF);
                end
                // a second header after the first must not count
                if ($urandom_range(0, 4) == 0) begin
                    add_header(PAT_LEN);
                    add_text("y");
                end
                add_random($urandom_range(0, 4));
            end else if (r < 80) begin
                // broken header, sometimes followed by a good one
                add_random($urandom_range(0, 3));
                add_header($urandom_range(1, 7));
                add_random(1);
                if ($urandom_range(0, 1) == 1) begin
                    add_header(PAT_LEN);
                    add_host($urandom_range(0, 6));
                    pkt_data.push_back(CH_CR);
                    pkt_data.push_back(CH_LF);
                end
                add_random($urandom_range(0, 3));
            end else begin
                // noise built from header characters and random bytes
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    r = $urandom_range(0, 9);
                    if (r < PAT_LEN) pkt_data.push_back(HDR_PAT[r]);
                    else             pkt_data.push_back(8'($urandom_range(0, 255)));
                end
            end
            send_packet();
            pkt_no++;
        end
        i_valid <= 1'b0;

        while (tracker.host_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/hhe_pkg.sv
hw/rtl/hhe_step.sv
hw/rtl/hhe_out_buf.sv
hw/rtl/http_host_header_extractor_core.sv
bench/http_host_header_extractor_core_test.sv
